[rtl/core/cst_pkg.sv]
package cst_pkg;

  localparam int NUM_SLOTS_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 8;

  localparam int KIND_W    = 2;
  localparam int STAT_W    = 2;
  localparam int IDENT_W   = 16;
  localparam int COUNT_W   = 16;
  localparam int START_W   = 15;
  localparam int TASK_W    = 8;
  localparam int NEXT_W    = 17;
  localparam int IN_DATA_W = 40;
  localparam int OUT_DATA_W = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_CREATE = 2'd0,
    KIND_DOWN   = 2'd1,
    KIND_UP     = 2'd2,
    KIND_CLOSE  = 2'd3
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NOSPACE = 2'd2
  } status_t;

  localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7FFF;
  localparam logic signed [COUNT_W-1:0] COUNT_MIN = 16'sh8000;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic scan;
    logic exec;
    logic wake_cap;
    logic load_out;
  } cst_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic hit;
    logic miss;
    logic is_create;
    logic wake;
    logic out_free;
  } cst_sts_t;

endpackage

[rtl/core/cst_ram.sv]
module cst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/cst_ctrl.sv]
module cst_ctrl
  import cst_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  cst_sts_t sts,
  output cst_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_EXEC   = 5'b00100,
    S_WAKE   = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
        if (in_tvalid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit) begin
          state_nxt = sts.is_create ? S_FINISH : S_EXEC;
        end else if (sts.miss) begin
          state_nxt = S_FINISH;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.wake ? S_WAKE : S_FINISH;
      end
      S_WAKE: begin
        cmd.wake_cap = 1'b1;
        state_nxt    = S_FINISH;
      end
      S_FINISH: begin
        // hold the result until the output register frees up
        cmd.load_out = sts.out_free;
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/core/cst_datapath.sv]
module cst_datapath
  import cst_pkg::*;
#(
  parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cst_cmd_t              cmd,
  output cst_sts_t              sts,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [KIND_W-1:0]     in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [STAT_W-1:0]     out_tuser
);

  localparam int SW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW  = $clog2(NUM_SLOTS + 1);
  localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW  = $clog2(QUEUE_DEPTH + 1);
  localparam int PSW = FW + 1;
  localparam int QD_TOTAL = NUM_SLOTS * QUEUE_DEPTH;
  localparam int AW  = (QD_TOTAL > 1) ? $clog2(QD_TOTAL) : 1;
  localparam int SLOT_W = IDENT_W + COUNT_W;

  // operation latched at accept
  kind_t               op_kind_r;
  logic [IDENT_W-1:0]  op_ident_r;
  logic [START_W-1:0]  op_start_r;
  logic [TASK_W-1:0]   op_task_r;

  // slot scan
  logic [CW-1:0]       scan_cnt_r;
  logic                chk_vld_r;
  logic [SW-1:0]       chk_idx_r;
  logic                issue;
  logic                chk_used;
  logic                match;

  // per-slot control state
  logic [NUM_SLOTS-1:0] slot_used_r;
  logic [QW-1:0]        wait_head_r [NUM_SLOTS];
  logic [FW-1:0]        wait_fill_r [NUM_SLOTS];
  logic [NEXT_W-1:0]    next_ident_r;

  // found slot
  logic [SW-1:0]               slot_r;
  logic signed [COUNT_W-1:0]   count_r;

  // slot RAM: ident in the low half, count in the high half
  logic              slot_we;
  logic [SW-1:0]     slot_waddr;
  logic [SLOT_W-1:0] slot_wdata;
  logic [SLOT_W-1:0] slot_rdata;

  // queue RAM
  logic              q_we;
  logic [AW-1:0]     q_waddr;
  logic [AW-1:0]     q_raddr;
  logic [AW-1:0]     q_base;
  logic [TASK_W-1:0] q_rdata;

  // execute step
  logic [FW-1:0]             fill;
  logic [QW-1:0]             head;
  logic [QW-1:0]             head_nxt;
  logic [PSW-1:0]            pos_sum;
  logic [QW-1:0]             tail_pos;
  logic signed [COUNT_W-1:0] cnt_dec;
  logic signed [COUNT_W-1:0] cnt_inc;
  logic signed [COUNT_W-1:0] cnt_nxt;
  logic                      down_floor;
  logic                      down_block;
  logic                      queue_full;
  logic                      up_wake;
  logic                      down_write;
  logic                      exhausted;
  logic                      create_ok;

  // result and output registers
  status_t             res_st_r;
  logic [IDENT_W-1:0]  res_cid_r;
  logic                res_blk_r;
  logic                res_woke_r;
  logic [TASK_W-1:0]   res_wtask_r;
  logic                out_vld_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [STAT_W-1:0]   out_user_r;

  assign issue     = scan_cnt_r < CW'(NUM_SLOTS);
  assign chk_used  = slot_used_r[chk_idx_r];
  assign match     = (op_kind_r == KIND_CREATE) ? !chk_used
                   : (chk_used && (slot_rdata[IDENT_W-1:0] == op_ident_r));
  assign exhausted = next_ident_r[NEXT_W-1];

  assign sts.hit       = chk_vld_r && match;
  assign sts.miss      = chk_vld_r && !match && (chk_idx_r == SW'(NUM_SLOTS - 1));
  assign sts.is_create = (op_kind_r == KIND_CREATE);
  assign sts.out_free  = !out_vld_r || out_tready;

  assign create_ok = cmd.scan && sts.hit && sts.is_create && !exhausted;

  always_comb begin
    fill       = wait_fill_r[slot_r];
    head       = wait_head_r[slot_r];
    cnt_dec    = count_r - 16'sd1;
    cnt_inc    = (count_r == COUNT_MAX) ? count_r : count_r + 16'sd1;
    down_floor = (count_r == COUNT_MIN);
    down_block = (count_r <= 16'sd0);
    queue_full = (fill >= FW'(QUEUE_DEPTH));
    up_wake    = (cnt_inc <= 16'sd0) && (fill != '0);
    down_write = !down_floor && (!down_block || !queue_full);
    pos_sum    = PSW'(head) + PSW'(fill);
    if (pos_sum >= PSW'(QUEUE_DEPTH)) begin
      pos_sum = pos_sum - PSW'(QUEUE_DEPTH);
    end
    tail_pos = pos_sum[QW-1:0];
    head_nxt = (head == QW'(QUEUE_DEPTH - 1)) ? '0 : head + QW'(1);
    cnt_nxt  = (op_kind_r == KIND_UP) ? cnt_inc : cnt_dec;
  end

  assign sts.wake = (op_kind_r == KIND_UP) && up_wake;

  // slot RAM port control
  always_comb begin
    if (cmd.scan) begin
      slot_we    = create_ok;
      slot_waddr = chk_idx_r;
      slot_wdata = {COUNT_W'(op_start_r), next_ident_r[IDENT_W-1:0]};
    end else begin
      slot_we    = cmd.exec && ((op_kind_r == KIND_UP)
                 || ((op_kind_r == KIND_DOWN) && down_write));
      slot_waddr = slot_r;
      slot_wdata = {cnt_nxt, op_ident_r};
    end
  end

  cst_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(NUM_SLOTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (slot_we),
    .waddr(slot_waddr),
    .wdata(slot_wdata),
    .raddr(scan_cnt_r[SW-1:0]),
    .rdata(slot_rdata)
  );

  assign q_base  = AW'(slot_r) * AW'(QUEUE_DEPTH);
  assign q_waddr = q_base + AW'(tail_pos);
  assign q_raddr = q_base + AW'(head);
  assign q_we    = cmd.exec && (op_kind_r == KIND_DOWN) && !down_floor
                && down_block && !queue_full;

  cst_ram #(
    .WIDTH(TASK_W),
    .DEPTH(QD_TOTAL)
  ) u_queue_ram (
    .clk  (clk),
    .we   (q_we),
    .waddr(q_waddr),
    .wdata(op_task_r),
    .raddr(q_raddr),
    .rdata(q_rdata)
  );

  // operation latch, scan pointer, found slot
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_kind_r  <= kind_t'(in_tuser);
      op_ident_r <= in_tdata[15:0];
      op_start_r <= in_tdata[30:16];
      op_task_r  <= in_tdata[38:31];
      scan_cnt_r <= '0;
    end else if (cmd.scan && issue) begin
      scan_cnt_r <= scan_cnt_r + CW'(1);
    end
    if (cmd.scan) begin
      chk_idx_r <= scan_cnt_r[SW-1:0];
    end
    if (cmd.scan && sts.hit) begin
      slot_r  <= chk_idx_r;
      count_r <= slot_rdata[SLOT_W-1:IDENT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_vld_r <= 1'b0;
    end else if (cmd.accept) begin
      chk_vld_r <= 1'b0;
    end else if (cmd.scan) begin
      chk_vld_r <= issue;
    end
  end

  // per-slot state and identifier counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_used_r  <= '0;
      next_ident_r <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        wait_head_r[i] <= '0;
        wait_fill_r[i] <= '0;
      end
    end else begin
      if (create_ok) begin
        slot_used_r[chk_idx_r] <= 1'b1;
        wait_head_r[chk_idx_r] <= '0;
        wait_fill_r[chk_idx_r] <= '0;
        next_ident_r           <= next_ident_r + NEXT_W'(1);
      end
      if (cmd.exec) begin
        case (op_kind_r)
          KIND_DOWN: begin
            if (q_we) begin
              wait_fill_r[slot_r] <= fill + FW'(1);
            end
          end
          KIND_UP: begin
            if (up_wake) begin
              wait_head_r[slot_r] <= head_nxt;
              wait_fill_r[slot_r] <= fill - FW'(1);
            end
          end
          KIND_CLOSE: begin
            if (fill == '0) begin
              slot_used_r[slot_r] <= 1'b0;
              wait_head_r[slot_r] <= '0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // result being built
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_st_r    <= ST_OK;
      res_cid_r   <= '0;
      res_blk_r   <= 1'b0;
      res_woke_r  <= 1'b0;
      res_wtask_r <= '0;
    end else if (cmd.scan && (sts.hit || sts.miss)) begin
      if (sts.is_create) begin
        if (sts.miss || exhausted) begin
          res_st_r <= ST_NOSPACE;
        end else begin
          res_cid_r <= next_ident_r[IDENT_W-1:0];
        end
      end else if (sts.miss) begin
        res_st_r <= ST_INVALID;
      end
    end else if (cmd.exec) begin
      case (op_kind_r)
        KIND_DOWN: begin
          if (down_floor || (down_block && queue_full)) begin
            res_st_r <= ST_NOSPACE;
          end else begin
            res_blk_r <= down_block;
          end
        end
        KIND_UP: begin
          res_woke_r <= up_wake;
        end
        KIND_CLOSE: begin
          if (fill != '0) begin
            res_st_r <= ST_INVALID;
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.wake_cap) begin
      res_wtask_r <= q_rdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_user_r <= res_st_r;
      out_data_r <= {6'd0, res_wtask_r, res_woke_r, res_blk_r, res_cid_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_hit_miss_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(sts.hit && sts.miss))
    else $error("slot scan reports hit and miss together");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> (fill <= FW'(QUEUE_DEPTH)))
    else $error("wait queue fill beyond depth");

  a_ident_step: assert property (@(posedge clk) disable iff (!rst_n)
    create_ok |=> (next_ident_r == $past(next_ident_r) + NEXT_W'(1)))
    else $error("identifier counter did not advance on create");

  a_blocked_ok: assert property (@(posedge clk) disable iff (!rst_n)
    res_blk_r |-> (res_st_r == ST_OK) && !res_woke_r)
    else $error("blocked result with failing status or wake");

endmodule

[rtl/core/counting_semaphore_table.sv]
// The slot table is scanned one slot per cycle through the slot RAM read port;
// down, up and close add an execute step, and a wakeup one more queue read.
// Only one transaction is in flight at a time.
// Reset (rst_n low, synchronous): all slots free, queues empty, identifier
// counter at zero; slot and queue RAM contents are not cleared.
module counting_semaphore_table
  import cst_pkg::*;
#(
  parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // sem_ident, start_value, task_num, pad
  input  logic [KIND_W-1:0]     in_tuser,   // kind
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // created_ident, blocked, woke, woken_task, pad
  output logic [STAT_W-1:0]     out_tuser   // status
);

  cst_cmd_t cmd;
  cst_sts_t sts;

  cst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cst_datapath #(
    .NUM_SLOTS  (NUM_SLOTS),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule
